@@ rtl/efq_pkg.sv @@
// ----------------------------------------------------------------------------
// efq_pkg
// Shared types, constants and the encoder rank table of the dimmer block.
// ----------------------------------------------------------------------------
package efq_pkg;

  localparam int unsigned LevelW      = 5;
  localparam int unsigned ClickW      = 8;
  localparam int unsigned HystW       = 2;
  localparam int unsigned PinsW       = 3;
  localparam int unsigned QueuedW     = 4;
  localparam int unsigned ExtW        = 2;
  localparam int unsigned ApbAddrW    = 4;
  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 16;
  localparam int unsigned QueueDepthDef = 8;

  localparam logic [LevelW-1:0] MaxLevelRst   = 5'd31;
  localparam logic [ClickW-1:0] BurstClickRst = 8'd10;
  localparam logic [HystW-1:0]  HystTopRst    = 2'd3;
  localparam logic [HystW-1:0]  HystRst       = 2'd1;
  localparam logic [ClickW-1:0] ClickSat      = 8'd255;
  localparam logic [LevelW-1:0] DipDepth      = 5'd2;

  // wrap states of the encoder sequence
  localparam logic [PinsW-1:0] PinsWrapLo = 3'b001;
  localparam logic [PinsW-1:0] PinsWrapHi = 3'b101;

  // register indexes (word address)
  typedef enum logic [1:0] {
    REG_MAX_LEVEL = 2'd0,
    REG_BURST     = 2'd1,
    REG_HYST_TOP  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] max_level;
    logic [ClickW-1:0] burst_clicks;
    logic [HystW-1:0]  hyst_top;
  } cfg_t;

  // queue command from the encoder logic for one transaction
  typedef struct packed {
    logic              push;
    logic              dip;
    logic [LevelW-1:0] lvl;
    logic              pop;
    logic              clear;
  } qcmd_t;

  // one queue memory entry: a level plus up to two dip levels behind it
  typedef struct packed {
    logic [LevelW-1:0] lvl;
    logic [ExtW-1:0]   ext;
    logic [LevelW-1:0] top;
  } qent_t;

  typedef struct packed {
    logic               apply;
    logic [LevelW-1:0]  level;
    logic [QueuedW-1:0] queued;
  } result_t;

  // gray-order rank of a pin state, state 7 ranks as 0
  function automatic logic [PinsW-1:0] rank_f(input logic [PinsW-1:0] s);
    logic [PinsW-1:0] r;
    case (s)
      3'd0:    r = 3'd0;
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd6;
      3'd5:    r = 3'd7;
      3'd6:    r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/encoder_dimmer_fade_queue_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_dimmer_fade_queue_unit
// Rotary encoder dimmer with a queue of brightness levels.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A new input transaction is
// taken every clock while the output register is empty or being drained, so
// the block sustains one item per cycle; the result appears in the cycle after
// acceptance. Per item the encoder state updates on acceptance, and the queue
// head is held read ahead from the registered-read queue memory, with a
// write to the head entry forwarded, so ticks right after pushes pop at full
// rate. Input tuser is the op (1 = tick), tdata the pin sample; output tuser
// is apply, tdata carries level and queue fill.
module encoder_dimmer_fade_queue_unit #(
  parameter int unsigned QueueDepth = efq_pkg::QueueDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [efq_pkg::InDataW-1:0]     s_axis_tdata,   // [2:0] pins
  input  logic                            s_axis_tuser,   // [0] op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [efq_pkg::OutDataW-1:0]    m_axis_tdata,   // [4:0] level, [8:5] queued
  output logic                            m_axis_tuser,   // [0] apply
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [efq_pkg::ApbAddrW-1:0]    paddr,
  input  logic [efq_pkg::ApbDataW-1:0]    pwdata,
  output logic [efq_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);

  efq_pkg::cfg_t    cfg;
  efq_pkg::qcmd_t   cmd;
  efq_pkg::result_t res;
  logic             accept;
  logic             m_valid_q, m_valid_d;
  efq_pkg::result_t m_res_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  efq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  efq_encoder u_encoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .op_i   (s_axis_tuser),
    .pins_i (s_axis_tdata[efq_pkg::PinsW-1:0]),
    .cfg_i  (cfg),
    .cmd_o  (cmd)
  );

  efq_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .cmd_i       (cmd),
    .max_level_i (cfg.max_level),
    .res_o       (res)
  );

  assign m_valid_d = accept || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.apply;
  assign m_axis_tdata  = efq_pkg::OutDataW'({m_res_q.queued, m_res_q.level});

endmodule

@@ rtl/efq_regs.sv @@
// ----------------------------------------------------------------------------
// efq_regs
// Configuration registers behind an APB-style slave port.
// ----------------------------------------------------------------------------
module efq_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [efq_pkg::ApbAddrW-1:0]    paddr,
  input  logic [efq_pkg::ApbDataW-1:0]    pwdata,
  output logic [efq_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready,
  output efq_pkg::cfg_t                   cfg_o
);

  efq_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        efq_pkg::REG_MAX_LEVEL: cfg_d.max_level    = pwdata[efq_pkg::LevelW-1:0];
        efq_pkg::REG_BURST:     cfg_d.burst_clicks = pwdata[efq_pkg::ClickW-1:0];
        efq_pkg::REG_HYST_TOP:  cfg_d.hyst_top     = pwdata[efq_pkg::HystW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_level    <= efq_pkg::MaxLevelRst;
      cfg_q.burst_clicks <= efq_pkg::BurstClickRst;
      cfg_q.hyst_top     <= efq_pkg::HystTopRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      efq_pkg::REG_MAX_LEVEL: prdata = efq_pkg::ApbDataW'(cfg_q.max_level);
      efq_pkg::REG_BURST:     prdata = efq_pkg::ApbDataW'(cfg_q.burst_clicks);
      efq_pkg::REG_HYST_TOP:  prdata = efq_pkg::ApbDataW'(cfg_q.hyst_top);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/efq_encoder.sv @@
// ----------------------------------------------------------------------------
// efq_encoder
// Encoder direction decode, hysteresis, click counting and level stepping.
// ----------------------------------------------------------------------------
module efq_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         op_i,
  input  logic [efq_pkg::PinsW-1:0]    pins_i,
  input  efq_pkg::cfg_t                cfg_i,
  output efq_pkg::qcmd_t               cmd_o
);

  logic [efq_pkg::PinsW-1:0]  last_pins_q, last_pins_d;
  logic [efq_pkg::HystW-1:0]  hyst_q, hyst_d;
  logic [efq_pkg::ClickW-1:0] click_q, click_d;
  logic [efq_pkg::LevelW-1:0] cur_q, cur_d;
  logic [efq_pkg::PinsW-1:0]  rank_new, rank_old;
  logic                       up;
  efq_pkg::qcmd_t             cmd;

  assign rank_new = efq_pkg::rank_f(pins_i);
  assign rank_old = efq_pkg::rank_f(last_pins_q);

  always_comb begin
    if (rank_new > rank_old) begin
      up = !(pins_i == efq_pkg::PinsWrapHi && last_pins_q == efq_pkg::PinsWrapLo);
    end else if (rank_new < rank_old) begin
      up = (pins_i == efq_pkg::PinsWrapLo && last_pins_q == efq_pkg::PinsWrapHi);
    end else begin
      up = 1'b1;
    end
  end

  always_comb begin
    last_pins_d = last_pins_q;
    hyst_d      = hyst_q;
    click_d     = click_q;
    cur_d       = cur_q;
    cmd         = '0;
    if (op_i) begin
      cmd.clear = (click_q > cfg_i.burst_clicks);
      cmd.pop   = !cmd.clear;
      click_d   = '0;
    end else if (pins_i != last_pins_q) begin
      last_pins_d = pins_i;
      if (up) begin
        if (click_q != efq_pkg::ClickSat) begin
          click_d = click_q + 1'b1;
        end
        if (hyst_q >= cfg_i.hyst_top) begin
          if (cur_q < cfg_i.max_level) begin
            cur_d = cur_q + 1'b1;
          end
          cmd.push = 1'b1;
          cmd.lvl  = cur_d;
          cmd.dip  = (cur_d == cfg_i.max_level);
        end else begin
          hyst_d = hyst_q + 1'b1;
        end
      end else begin
        click_d = '0;
        if (hyst_q == '0) begin
          if (cur_q != '0) begin
            cur_d = cur_q - 1'b1;
          end
          cmd.push = 1'b1;
          cmd.lvl  = cur_d;
        end else begin
          hyst_d = hyst_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= '0;
      hyst_q      <= efq_pkg::HystRst;
      click_q     <= '0;
      cur_q       <= '0;
    end else if (en_i) begin
      last_pins_q <= last_pins_d;
      hyst_q      <= hyst_d;
      click_q     <= click_d;
      cur_q       <= cur_d;
    end
  end

  assign cmd_o = cmd;

endmodule

@@ rtl/efq_queue.sv @@
// ----------------------------------------------------------------------------
// efq_queue
// Level queue in a two-port synchronous memory. Each entry holds a level and
// up to two dip levels, so a step with its dip is a single write. The head
// entry is read ahead every cycle, with forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module efq_queue #(
  parameter int unsigned QueueDepth = efq_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  efq_pkg::qcmd_t              cmd_i,
  input  logic [efq_pkg::LevelW-1:0]  max_level_i,
  output efq_pkg::result_t            res_o
);

  localparam int unsigned PtrW  = $clog2(QueueDepth);
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  efq_pkg::qent_t mem [QueueDepth];

  logic [PtrW-1:0]          hp_q, hp_d, tp_q, tp_d;
  logic [efq_pkg::ExtW-1:0] sub_q, sub_d;
  logic [FillW-1:0]         fill_q, fill_d, room;
  efq_pkg::qent_t           rd_q, fwd_data_q, head_ent, wdata;
  logic                     fwd_q, fwd_d;
  logic [efq_pkg::ExtW-1:0] want, take;
  logic                     we, pop_ok;
  logic [efq_pkg::LevelW-1:0] dip_lo, pop_lvl;

  function automatic logic [PtrW-1:0] inc_f(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_ent = fwd_q ? fwd_data_q : rd_q;
  assign room     = FillW'(QueueDepth) - fill_q;
  assign want     = cmd_i.dip ? 2'd3 : 2'd1;
  assign take     = (room >= FillW'(want)) ? want : room[efq_pkg::ExtW-1:0];
  assign we       = en_i && cmd_i.push && (room != '0);
  assign pop_ok   = cmd_i.pop && (fill_q != '0);

  always_comb begin
    wdata.lvl = cmd_i.lvl;
    wdata.ext = take - 1'b1;
    wdata.top = max_level_i;
  end

  // level at the current position inside the head entry
  assign dip_lo = (head_ent.top >= efq_pkg::DipDepth) ?
                  head_ent.top - efq_pkg::DipDepth : '0;
  always_comb begin
    case (sub_q)
      2'd0:    pop_lvl = head_ent.lvl;
      2'd1:    pop_lvl = dip_lo;
      default: pop_lvl = head_ent.top;
    endcase
  end

  always_comb begin
    hp_d   = hp_q;
    tp_d   = tp_q;
    sub_d  = sub_q;
    fill_d = fill_q;
    if (en_i) begin
      if (cmd_i.clear) begin
        hp_d   = '0;
        tp_d   = '0;
        sub_d  = '0;
        fill_d = '0;
      end else if (pop_ok) begin
        fill_d = fill_q - 1'b1;
        if (sub_q == head_ent.ext) begin
          hp_d  = inc_f(hp_q);
          sub_d = '0;
        end else begin
          sub_d = sub_q + 1'b1;
        end
      end else if (we) begin
        tp_d   = inc_f(tp_q);
        fill_d = fill_q + FillW'(take);
      end
    end
  end

  assign fwd_d = we && (tp_q == hp_d);

  always_comb begin
    res_o.apply  = cmd_i.clear | pop_ok;
    res_o.level  = cmd_i.clear ? max_level_i : (pop_ok ? pop_lvl : '0);
    res_o.queued = efq_pkg::QueuedW'(fill_d);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[tp_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q       <= mem[hp_d];
    fwd_data_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q   <= '0;
      tp_q   <= '0;
      sub_q  <= '0;
      fill_q <= '0;
      fwd_q  <= 1'b0;
    end else begin
      hp_q   <= hp_d;
      tp_q   <= tp_d;
      sub_q  <= sub_d;
      fill_q <= fill_d;
      fwd_q  <= fwd_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(QueueDepth))
    else $error("queue fill above depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && cmd_i.clear |=> fill_q == '0)
    else $error("queue not empty after clear");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && pop_ok |=> fill_q == $past(fill_q) - 1'b1)
    else $error("pop did not take exactly one level");

  a_sub_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != '0 |-> sub_q <= head_ent.ext)
    else $error("head position beyond entry");

endmodule

@@ verif/dimmer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dimmer_checker
// Watches the stream and register ports of the encoder dimmer, keeps its own
// copy of the encoder, hysteresis, click and level-queue state, and compares
// every output transaction with the result predicted for the oldest input.
// ----------------------------------------------------------------------------
module dimmer_checker
  import efq_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [2:0] pins
  input  logic                s_axis_tuser,   // [0] op
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // [4:0] level, [8:5] queued
  input  logic                m_axis_tuser,   // [0] apply
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output int unsigned         mismatches_o,
  output int unsigned         outstanding_o
);

  cfg_t              cfg;
  logic [PinsW-1:0]  prev_pins;
  logic [HystW-1:0]  hyst;
  logic [ClickW-1:0] clicks;
  logic [LevelW-1:0] lvl_now;
  logic [LevelW-1:0] level_fifo [Depth];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  int unsigned       fifo_cnt;
  result_t           results_due [$];
  result_t           want;
  result_t           got;

  // position of a pin state along the detent sequence, 7 sits with 0
  function automatic logic [PinsW-1:0] pin_rank(input logic [PinsW-1:0] s);
    logic [PinsW-1:0] r;
    case (s)
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd6;
      3'd5:    r = 3'd7;
      3'd6:    r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // pushes into a full queue are lost
  function automatic void enqueue_level(input logic [LevelW-1:0] v);
    if (fifo_cnt < Depth) begin
      level_fifo[wr_ptr] = v;
      wr_ptr = (wr_ptr + 1) % Depth;
      fifo_cnt++;
    end
  endfunction

  function automatic result_t dimmer_result(input logic op, input logic [PinsW-1:0] pins);
    result_t          r;
    logic [PinsW-1:0] rank_new;
    logic [PinsW-1:0] rank_old;
    logic             up;
    r = '0;
    if (op) begin
      if (clicks > cfg.burst_clicks) begin
        rd_ptr = 0;
        wr_ptr = 0;
        fifo_cnt = 0;
        r.apply = 1'b1;
        r.level = cfg.max_level;
      end else if (fifo_cnt != 0) begin
        r.apply = 1'b1;
        r.level = level_fifo[rd_ptr];
        rd_ptr = (rd_ptr + 1) % Depth;
        fifo_cnt--;
      end
      clicks = '0;
    end else if (pins != prev_pins) begin
      rank_new = pin_rank(pins);
      rank_old = pin_rank(prev_pins);
      // the wrap between the two end states runs against the rank order
      if (rank_new > rank_old) begin
        up = !(pins == PinsWrapHi && prev_pins == PinsWrapLo);
      end else if (rank_new < rank_old) begin
        up = (pins == PinsWrapLo && prev_pins == PinsWrapHi);
      end else begin
        up = 1'b1;
      end
      if (up) begin
        if (clicks != ClickSat) clicks++;
        if (hyst >= cfg.hyst_top) begin
          if (lvl_now < cfg.max_level) lvl_now++;
          enqueue_level(lvl_now);
          // reaching the top adds a short dip
          if (lvl_now == cfg.max_level) begin
            enqueue_level(cfg.max_level >= DipDepth ? cfg.max_level - DipDepth : '0);
            enqueue_level(cfg.max_level);
          end
        end else begin
          hyst++;
        end
      end else begin
        clicks = '0;
        if (hyst == 0) begin
          if (lvl_now != 0) lvl_now--;
          enqueue_level(lvl_now);
        end else begin
          hyst--;
        end
      end
      prev_pins = pins;
    end
    r.queued = fifo_cnt[QueuedW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.max_level = MaxLevelRst;
      cfg.burst_clicks = BurstClickRst;
      cfg.hyst_top = HystTopRst;
      prev_pins = '0;
      hyst = HystRst;
      clicks = '0;
      lvl_now = '0;
      rd_ptr = 0;
      wr_ptr = 0;
      fifo_cnt = 0;
      results_due.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ApbAddrW-1:2])
          REG_MAX_LEVEL: cfg.max_level = pwdata[LevelW-1:0];
          REG_BURST:     cfg.burst_clicks = pwdata[ClickW-1:0];
          REG_HYST_TOP:  cfg.hyst_top = pwdata[HystW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.apply = m_axis_tuser;
        got.level = m_axis_tdata[LevelW-1:0];
        got.queued = m_axis_tdata[LevelW +: QueuedW];
        if (results_due.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected result: expected none, %s", $time,
                   $sformatf("actual apply=%0b level=%0d queued=%0d",
                             got.apply, got.level, got.queued));
        end else begin
          want = results_due.pop_front();
          if (got != want || m_axis_tdata[OutDataW-1:LevelW+QueuedW] != '0) begin
            mismatches_o++;
            $display("%0t: result mismatch: expected apply=%0b level=%0d queued=%0d pad=0, %s",
                     $time, want.apply, want.level, want.queued,
                     $sformatf("actual apply=%0b level=%0d queued=%0d pad=%0h",
                               got.apply, got.level, got.queued,
                               m_axis_tdata[OutDataW-1:LevelW+QueuedW]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(dimmer_result(s_axis_tuser, s_axis_tdata[PinsW-1:0]));
      outstanding_o = results_due.size();
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the encoder dimmer with pin samples and ticks: a directed opening
// over the direction rules, the level top and dip, a full queue and a click
// burst, then random knob turns, noise and ticks under several register
// settings with random stalls on both streams. Checking is in dimmer_checker.
// ----------------------------------------------------------------------------
module tb;
  import efq_pkg::*;

  localparam int unsigned StallLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned         mismatches;
  int unsigned         outstanding;
  int unsigned         stall_cnt = 0;
  bit                  calm = 1'b0;
  int unsigned         ring_pos = 0;
  logic [PinsW-1:0]    sent_pins = '0;

  encoder_dimmer_fade_queue_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dimmer_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 19);
  end

  // nothing accepted on any port for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == StallLimit) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send(input logic op, input logic [PinsW-1:0] pins);
    int unsigned idle;
    idle = 0;
    while (!calm && $urandom_range(99) < 19) idle++;
    if (idle != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= InDataW'(pins);
    if (!op) sent_pins = pins;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // well-formed knob rotation along 1,3,2,6,4,5 and around
  task automatic turn(input bit cw, input int unsigned steps);
    logic [PinsW-1:0] p;
    repeat (steps) begin
      ring_pos = cw ? (ring_pos + 1) % 6 : (ring_pos + 5) % 6;
      case (ring_pos)
        0:       p = 3'd1;
        1:       p = 3'd3;
        2:       p = 3'd2;
        3:       p = 3'd6;
        4:       p = 3'd4;
        default: p = 3'd5;
      endcase
      send(1'b0, p);
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [ApbDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic configure(input logic [LevelW-1:0] top_lvl, input logic [ClickW-1:0] burst,
                           input logic [HystW-1:0] hyst_top);
    drain();
    write_reg(REG_MAX_LEVEL, ApbDataW'(top_lvl));
    write_reg(REG_BURST, ApbDataW'(burst));
    write_reg(REG_HYST_TOP, ApbDataW'(hyst_top));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly knob turns and ticks, some unchanged samples and pin noise
  task automatic wander(input int unsigned n, input int unsigned up_pct);
    int unsigned done;
    int unsigned r;
    int unsigned k;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < 50) begin
        k = $urandom_range(1, 6);
        turn($urandom_range(99) < up_pct, k);
        done += k;
      end else if (r < 80) begin
        send(1'b1, PinsW'($urandom));
        done++;
      end else if (r < 88) begin
        send(1'b0, sent_pins);
      end else begin
        send(1'b0, PinsW'($urandom_range(7)));
        done++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // direction rules at reset settings
    send(1'b1, 3'd7);          // tick with nothing queued
    send(1'b0, 3'd0);          // unchanged sample
    send(1'b0, 3'd7);          // equal rank counts as up
    send(1'b0, 3'd1);
    send(1'b0, 3'd5);          // wrap going down
    send(1'b0, 3'd1);          // wrap going up
    send(1'b0, 3'd3);          // first step up

    // low top: dip, full queue drops, burst, step down at zero
    configure(5'd2, 8'd3, 2'd1);
    turn(1'b1, 9);
    send(1'b1, 3'd0);
    turn(1'b1, 2);
    send(1'b1, 3'd5);
    turn(1'b0, 5);
    send(1'b1, 3'd2);

    configure(5'd31, 8'd0, 2'd3);
    wander(110, 65);
    configure(5'd2, 8'd255, 2'd1);
    wander(110, 55);
    calm = 1'b1;
    configure(LevelW'($urandom_range(2, 31)), ClickW'($urandom_range(12)),
              HystW'($urandom_range(1, 3)));
    wander(110, 65);
    calm = 1'b0;
    configure(LevelW'($urandom_range(2, 31)),
              ClickW'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(12)),
              2'd2);
    wander(110, 65);
    configure(LevelW'($urandom_range(2, 31)), ClickW'($urandom_range(12)),
              HystW'($urandom_range(1, 3)));
    wander(110, 60);

    // click counter saturates just above the threshold
    configure(LevelW'($urandom_range(2, 31)), 8'd254, 2'd3);
    turn(1'b1, 258);
    send(1'b1, 3'd6);
    send(1'b1, 3'd1);

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
